// ----- design/bcdcdt_pkg.sv -----
// Package for the BCD countdown timer with digit editor.
// Holds the command and key codes, reset constants and the digit-limit function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bcdcdt_pkg;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_EDIT   = 2'd1,
        CMD_KEY    = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    localparam logic [5:0] KEY_UP      = 6'b000001;
    localparam logic [5:0] KEY_DOWN    = 6'b000010;
    localparam logic [5:0] KEY_RIGHT   = 6'b000100;
    localparam logic [5:0] KEY_LEFT    = 6'b001000;
    localparam logic [5:0] KEY_CANCEL  = 6'b010000;
    localparam logic [5:0] KEY_CONFIRM = 6'b100000;

    localparam logic [15:0] TPS_RESET = 16'd1000;

    localparam logic [3:0] DIGIT_MAX_DEC      = 4'd9;
    localparam logic [3:0] DIGIT_MAX_TENS     = 4'd5;
    localparam logic [3:0] DIGIT_MAX_HOUR_TEN = 4'd2;
    localparam logic [3:0] DIGIT_MAX_HOUR_ONE = 4'd3;

    localparam logic EDIT_TIMER = 1'b0;
    localparam logic EDIT_CLOCK = 1'b1;

    // Largest value the digit at a given position may take while editing.
    function automatic logic [3:0] digit_max(input logic [1:0] pos, input logic is_clock,
                                             input logic [3:0] first_digit);
        logic [3:0] mx;
        mx = DIGIT_MAX_DEC;
        if (pos == 2'd0 && is_clock) begin
            mx = DIGIT_MAX_HOUR_TEN;
        end else if (pos == 2'd1 && is_clock && first_digit == DIGIT_MAX_HOUR_TEN) begin
            mx = DIGIT_MAX_HOUR_ONE;
        end else if (pos == 2'd2) begin
            mx = DIGIT_MAX_TENS;
        end
        return mx;
    endfunction

endpackage

`default_nettype wire

// ----- design/bcd_countdown_timer_with_digit_editor.sv -----
// Top level of the BCD countdown timer with digit editor: input register, state,
// next-state logic and result register. Depends on bcdcdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one word per cycle on the s_ channel (tick, begin edit or key
// press) and returns exactly one result word per input word on the m_ channel,
// carrying the editor, timer and clock state as it stands after that word. An
// accepted word is held in the input register and is then processed into the
// state and result registers, so the block keeps up one word per clock as
// long as m_ready is high; the only stall comes from the output side. The
// single configuration register, ticks_per_second, is written through
// cfg_wr_en/cfg_wr_data and should only be changed while no word is in
// flight.
module bcd_countdown_timer_with_digit_editor (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [5:0]  s_key,
    input  wire logic        s_target,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_edit_active,
    output logic             m_edit_target_out,
    output logic [1:0]       m_cursor_pos,
    output logic [15:0]      m_edit_value,
    output logic [15:0]      m_timer_value,
    output logic [15:0]      m_clock_value,
    output logic             m_is_running,
    output logic             m_is_expired,
    output logic             m_committed,
    output logic             m_cancelled
);
    import bcdcdt_pkg::*;

    // Prescale register.
    logic [15:0] tps_reg;

    // Input register.
    logic        in_valid_reg;
    cmd_t        in_cmd_reg;
    logic [5:0]  in_key_reg;
    logic        in_target_reg;

    // Architectural state. Digit 0 is the leftmost digit.
    logic [3:0]  edit_reg [4];
    logic [3:0]  timer_reg [4];
    logic [3:0]  clock_reg [4];
    logic [1:0]  cursor_reg;
    logic        editing_reg;
    logic        target_reg;
    logic [15:0] tick_count_reg;
    logic        running_reg;
    logic        expired_reg;

    logic [3:0]  edit_next [4];
    logic [3:0]  timer_next [4];
    logic [3:0]  clock_next [4];
    logic [1:0]  cursor_next;
    logic        editing_next;
    logic        target_next;
    logic [15:0] tick_count_next;
    logic        running_next;
    logic        expired_next;
    logic        commit_next;
    logic        cancel_next;

    // Result register valid flag.
    logic        out_valid_reg;

    // The input word moves into the state and result registers when the
    // result register is empty or is being drained this cycle.
    logic        advance;

    // Helpers for the digit editor and the prescaler.
    logic [3:0]  cur_digit;
    logic [3:0]  cur_max;
    logic [3:0]  new_digit;
    logic        digit_write;
    logic [16:0] tick_sum;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;

    assign cur_digit = edit_reg[cursor_reg];
    assign cur_max   = digit_max(cursor_reg, target_reg, edit_reg[0]);
    assign tick_sum  = {1'b0, tick_count_reg} + 17'd1;

    // New value of the digit under the cursor for up and down keys. Up wraps
    // past the maximum to zero; down holds at zero and saturates to the maximum
    // for a digit that somehow sits above it.
    always_comb begin
        new_digit   = cur_digit;
        digit_write = 1'b0;
        if (in_key_reg == KEY_UP) begin
            digit_write = 1'b1;
            new_digit   = (cur_digit >= cur_max) ? 4'd0 : cur_digit + 4'd1;
        end else if (in_key_reg == KEY_DOWN && cur_digit != 4'd0) begin
            digit_write = 1'b1;
            new_digit   = ((cur_digit - 4'd1) > cur_max) ? cur_max : cur_digit - 4'd1;
        end
    end

    always_comb begin
        edit_next       = edit_reg;
        timer_next      = timer_reg;
        clock_next      = clock_reg;
        cursor_next     = cursor_reg;
        editing_next    = editing_reg;
        target_next     = target_reg;
        tick_count_next = tick_count_reg;
        running_next    = running_reg;
        expired_next    = expired_reg;
        commit_next     = 1'b0;
        cancel_next     = 1'b0;

        case (in_cmd_reg)
            CMD_TICK: begin
                if (running_reg) begin
                    if (tick_sum >= {1'b0, tps_reg}) begin
                        tick_count_next = '0;
                        // Borrow from the rightmost nonzero digit; digits to its
                        // right reload with their maxima (mm:ss is 9,5,9 below).
                        if (timer_reg[3] != 4'd0) begin
                            timer_next[3] = timer_reg[3] - 4'd1;
                        end else if (timer_reg[2] != 4'd0) begin
                            timer_next[2] = timer_reg[2] - 4'd1;
                            timer_next[3] = DIGIT_MAX_DEC;
                        end else if (timer_reg[1] != 4'd0) begin
                            timer_next[1] = timer_reg[1] - 4'd1;
                            timer_next[2] = DIGIT_MAX_TENS;
                            timer_next[3] = DIGIT_MAX_DEC;
                        end else if (timer_reg[0] != 4'd0) begin
                            timer_next[0] = timer_reg[0] - 4'd1;
                            timer_next[1] = DIGIT_MAX_DEC;
                            timer_next[2] = DIGIT_MAX_TENS;
                            timer_next[3] = DIGIT_MAX_DEC;
                        end else begin
                            expired_next = 1'b1;
                            running_next = 1'b0;
                        end
                    end else begin
                        tick_count_next = tick_sum[15:0];
                    end
                end
            end
            CMD_EDIT: begin
                editing_next = 1'b1;
                target_next  = in_target_reg;
                cursor_next  = '0;
                for (int i = 0; i < 4; i++) begin
                    edit_next[i] = '0;
                end
            end
            CMD_KEY: begin
                if (editing_reg) begin
                    if (digit_write) begin
                        edit_next[cursor_reg] = new_digit;
                        // Setting hour tens to 2 pulls hour ones down to 3.
                        if (cursor_reg == 2'd0 && target_reg == EDIT_CLOCK &&
                            new_digit == DIGIT_MAX_HOUR_TEN &&
                            edit_reg[1] > DIGIT_MAX_HOUR_ONE) begin
                            edit_next[1] = DIGIT_MAX_HOUR_ONE;
                        end
                    end else if (in_key_reg == KEY_RIGHT) begin
                        cursor_next = cursor_reg + 2'd1;
                    end else if (in_key_reg == KEY_LEFT) begin
                        cursor_next = cursor_reg - 2'd1;
                    end else if (in_key_reg == KEY_CANCEL) begin
                        editing_next = 1'b0;
                        cancel_next  = 1'b1;
                    end else if (in_key_reg == KEY_CONFIRM) begin
                        if (target_reg == EDIT_CLOCK) begin
                            clock_next = edit_reg;
                        end else begin
                            timer_next   = edit_reg;
                            expired_next = 1'b0;
                            running_next = 1'b1;
                        end
                        editing_next = 1'b0;
                        commit_next  = 1'b1;
                    end
                end else begin
                    // With the editor closed, up pauses or resumes and cancel
                    // clears the countdown and marks it expired.
                    if (in_key_reg == KEY_UP) begin
                        running_next = !running_reg;
                    end else if (in_key_reg == KEY_CANCEL) begin
                        for (int i = 0; i < 4; i++) begin
                            timer_next[i] = '0;
                        end
                        expired_next = 1'b1;
                        running_next = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg <= TPS_RESET;
        end else if (cfg_wr_en) begin
            tps_reg <= cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg    <= cmd_t'(s_cmd);
            in_key_reg    <= s_key;
            in_target_reg <= s_target;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                edit_reg[i]  <= '0;
                timer_reg[i] <= '0;
                clock_reg[i] <= '0;
            end
            cursor_reg     <= '0;
            editing_reg    <= 1'b0;
            target_reg     <= EDIT_TIMER;
            tick_count_reg <= '0;
            running_reg    <= 1'b0;
            expired_reg    <= 1'b0;
        end else if (advance) begin
            edit_reg       <= edit_next;
            timer_reg      <= timer_next;
            clock_reg      <= clock_next;
            cursor_reg     <= cursor_next;
            editing_reg    <= editing_next;
            target_reg     <= target_next;
            tick_count_reg <= tick_count_next;
            running_reg    <= running_next;
            expired_reg    <= expired_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_edit_active     <= editing_next;
            m_edit_target_out <= target_next;
            m_cursor_pos      <= cursor_next;
            m_edit_value      <= {edit_next[0], edit_next[1], edit_next[2], edit_next[3]};
            m_timer_value     <= {timer_next[0], timer_next[1], timer_next[2], timer_next[3]};
            m_clock_value     <= {clock_next[0], clock_next[1], clock_next[2], clock_next[3]};
            m_is_running      <= running_next;
            m_is_expired      <= expired_next;
            m_committed       <= commit_next;
            m_cancelled       <= cancel_next;
        end
    end

`ifndef ASSERT_OFF
    // A word can never both confirm and cancel an edit.
    a_commit_cancel_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_committed && m_cancelled))
        else $error("commit and cancel pulsed together");

    // Confirming or cancelling always closes the editor.
    a_close_on_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_committed || m_cancelled)) |-> !m_edit_active)
        else $error("editor still open after commit or cancel");

    // A timer commit starts the countdown.
    a_timer_commit_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_committed && m_edit_target_out == EDIT_TIMER) |-> m_is_running)
        else $error("timer commit did not start the countdown");

    // Begin edit opens the editor with the cursor on the leftmost digit.
    a_begin_edit: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd_reg == CMD_EDIT) |=> (editing_reg && cursor_reg == 2'd0))
        else $error("begin edit did not open the editor");

    // An empty input register always takes a new word.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stalled with empty input register");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// Self-checking regression for bcd_countdown_timer_with_digit_editor.
// Depends on bcdcdt_pkg and the block's top level. The bench predicts every
// result word itself and checks each one field by field.
module tb_top;
    import bcdcdt_pkg::*;

    localparam int     CLK_HALF_NS   = 4;
    localparam int     RESET_CYCLES  = 10;
    localparam int     MAX_IDLE      = 18;
    localparam int     SETTLE_CYCLES = 6;
    localparam int     DRAIN_LIMIT   = 5000;
    localparam int     MAX_REPORTS   = 10;
    localparam int     RANDOM_WORDS  = 300;
    localparam int     HOLD_CYCLES   = 200;
    localparam longint RUN_LIMIT_NS  = 64'd4_000_000;

    // One result word as the block should present it.
    typedef struct packed {
        logic        edit_active;
        logic        edit_target;
        logic [1:0]  cursor;
        logic [15:0] edit_value;
        logic [15:0] timer_value;
        logic [15:0] clock_value;
        logic        running;
        logic        expired;
        logic        committed;
        logic        cancelled;
    } status_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [5:0]  s_key;
    logic        s_target;
    logic        m_valid;
    logic        m_ready;
    logic        m_edit_active;
    logic        m_edit_target_out;
    logic [1:0]  m_cursor_pos;
    logic [15:0] m_edit_value;
    logic [15:0] m_timer_value;
    logic [15:0] m_clock_value;
    logic        m_is_running;
    logic        m_is_expired;
    logic        m_committed;
    logic        m_cancelled;

    bcd_countdown_timer_with_digit_editor u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_key             (s_key),
        .s_target          (s_target),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_edit_active     (m_edit_active),
        .m_edit_target_out (m_edit_target_out),
        .m_cursor_pos      (m_cursor_pos),
        .m_edit_value      (m_edit_value),
        .m_timer_value     (m_timer_value),
        .m_clock_value     (m_clock_value),
        .m_is_running      (m_is_running),
        .m_is_expired      (m_is_expired),
        .m_committed       (m_committed),
        .m_cancelled       (m_cancelled)
    );

    always begin
        #CLK_HALF_NS aclk = 1'b1;
        #CLK_HALF_NS aclk = 1'b0;
    end

    // Predicted state of the block. Digit 0 is the leftmost digit and lands in
    // the top nibble, so each packed array reads directly as the 16-bit value.
    logic [0:3][3:0] buf_digits;
    logic [0:3][3:0] clk_digits;
    logic [0:3][3:0] cnt_digits;
    logic [1:0]      sel_digit;
    logic            edit_open;
    logic            edit_on_clock;
    logic [15:0]     prescale_count;
    logic [15:0]     prescale_limit;
    logic            count_running;
    logic            count_expired;

    // Result words predicted for accepted input words, oldest first.
    status_t status_q[$];

    // Pacing controls. A burst flag removes the random idle cycles on that
    // side; a nonzero hold request makes the result side refuse words until
    // it has counted the request down.
    bit tx_burst;
    bit rx_burst;
    int rx_hold_cycles;

    int words_sent;
    int results_seen;
    int failures;
    int commits;
    int cancels;
    int expiries;
    int config_writes;

    function automatic logic [5:0] any_key();
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic any_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic clear_prediction();
        buf_digits     = '0;
        clk_digits     = '0;
        cnt_digits     = '0;
        sel_digit      = 2'd0;
        edit_open      = 1'b0;
        edit_on_clock  = EDIT_TIMER;
        prescale_count = '0;
        prescale_limit = TPS_RESET;
        count_running  = 1'b0;
        count_expired  = 1'b0;
    endtask

    // Highest value the digit at a position may take in the editor. Hour tens
    // stop at 2, and hour ones stop at 3 once hour tens are 2.
    function automatic logic [3:0] edit_limit(input logic [1:0] pos);
        logic [3:0] lim;
        case (pos)
            2'd0: lim = edit_on_clock ? DIGIT_MAX_HOUR_TEN : DIGIT_MAX_DEC;
            2'd1: lim = (edit_on_clock && buf_digits[0] == DIGIT_MAX_HOUR_TEN) ?
                        DIGIT_MAX_HOUR_ONE : DIGIT_MAX_DEC;
            2'd2: lim = DIGIT_MAX_TENS;
            default: lim = DIGIT_MAX_DEC;
        endcase
        return lim;
    endfunction

    // One second off the mm:ss countdown with BCD borrow. An all-zero count
    // instead flags expiry and stops the countdown.
    task automatic take_second();
        int   i;
        logic done;
        done = 1'b0;
        for (i = 3; i >= 0 && !done; i--) begin
            if (cnt_digits[i] != 4'd0) begin
                cnt_digits[i] = cnt_digits[i] - 4'd1;
                if (i <= 2) cnt_digits[3] = DIGIT_MAX_DEC;
                if (i <= 1) cnt_digits[2] = DIGIT_MAX_TENS;
                if (i == 0) cnt_digits[1] = DIGIT_MAX_DEC;
                done = 1'b1;
            end
        end
        if (!done) begin
            count_expired = 1'b1;
            count_running = 1'b0;
            expiries++;
        end
    endtask

    // Up wraps past the limit to zero; down stops at zero and pulls a digit
    // above its limit back to the limit. Hour tens reaching 2 clamps hour ones.
    task automatic step_digit(input logic up);
        logic [3:0] cur;
        logic [3:0] lim;
        logic [3:0] nxt;
        cur = buf_digits[sel_digit];
        lim = edit_limit(sel_digit);
        if (up || cur != 4'd0) begin
            if (up) begin
                nxt = (cur >= lim) ? 4'd0 : cur + 4'd1;
            end else begin
                nxt = cur - 4'd1;
                if (nxt > lim) nxt = lim;
            end
            buf_digits[sel_digit] = nxt;
            if (sel_digit == 2'd0 && edit_on_clock && nxt == DIGIT_MAX_HOUR_TEN &&
                buf_digits[1] > DIGIT_MAX_HOUR_ONE) begin
                buf_digits[1] = DIGIT_MAX_HOUR_ONE;
            end
        end
    endtask

    // Applies one accepted word to the predicted state and queues the result
    // word that it must produce.
    task automatic predict_status(input cmd_t cmd, input logic [5:0] key, input logic target);
        status_t st;
        logic    did_commit;
        logic    did_cancel;
        did_commit = 1'b0;
        did_cancel = 1'b0;
        case (cmd)
            CMD_TICK: begin
                // The prescaler only moves while the countdown runs, editor or not.
                if (count_running) begin
                    if ({1'b0, prescale_count} + 17'd1 >= {1'b0, prescale_limit}) begin
                        prescale_count = '0;
                        take_second();
                    end else begin
                        prescale_count = prescale_count + 16'd1;
                    end
                end
            end
            CMD_EDIT: begin
                edit_open     = 1'b1;
                edit_on_clock = target;
                sel_digit     = 2'd0;
                buf_digits    = '0;
            end
            CMD_KEY: begin
                if (edit_open) begin
                    case (key)
                        KEY_UP:    step_digit(1'b1);
                        KEY_DOWN:  step_digit(1'b0);
                        KEY_RIGHT: sel_digit = sel_digit + 2'd1;
                        KEY_LEFT:  sel_digit = sel_digit - 2'd1;
                        KEY_CANCEL: begin
                            edit_open  = 1'b0;
                            did_cancel = 1'b1;
                        end
                        KEY_CONFIRM: begin
                            if (edit_on_clock == EDIT_CLOCK) begin
                                clk_digits = buf_digits;
                            end else begin
                                cnt_digits    = buf_digits;
                                count_expired = 1'b0;
                                count_running = 1'b1;
                            end
                            edit_open  = 1'b0;
                            did_commit = 1'b1;
                        end
                        default: ;
                    endcase
                end else if (key == KEY_UP) begin
                    count_running = !count_running;
                end else if (key == KEY_CANCEL) begin
                    cnt_digits    = '0;
                    count_expired = 1'b1;
                    count_running = 1'b0;
                end
            end
            default: ;
        endcase
        if (did_commit) commits++;
        if (did_cancel) cancels++;
        st.edit_active = edit_open;
        st.edit_target = edit_on_clock;
        st.cursor      = sel_digit;
        st.edit_value  = buf_digits;
        st.timer_value = cnt_digits;
        st.clock_value = clk_digits;
        st.running     = count_running;
        st.expired     = count_expired;
        st.committed   = did_commit;
        st.cancelled   = did_cancel;
        status_q.push_back(st);
    endtask

    // Offers one word and returns at the edge where it is taken. Valid is only
    // lowered when an idle gap is drawn, so back-to-back words keep it high.
    task automatic send_word(input cmd_t cmd, input logic [5:0] key, input logic target);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_cmd    <= cmd;
        s_key    <= key;
        s_target <= target;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_status(cmd, key, target);
        words_sent++;
    endtask

    // Stops offering words, waits for every predicted result, then lets the
    // pipeline settle.
    task automatic wait_drained();
        int n;
        s_valid <= 1'b0;
        n = 0;
        while (status_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_prescale(input logic [15:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        prescale_limit  = value;
        config_writes++;
    endtask

    task automatic press(input logic [5:0] key);
        send_word(CMD_KEY, key, any_bit());
    endtask

    task automatic tick_run(input int count);
        repeat (count) send_word(CMD_TICK, any_key(), any_bit());
    endtask

    // The unused command must leave everything at its reset value.
    task automatic test_reset_and_unused();
        send_word(CMD_UNUSED, any_key(), any_bit());
    endtask

    // Timer edit: down at zero does nothing, left wraps to the last digit and
    // a two-bit key is ignored. Commit gives 10:01 and starts the countdown.
    task automatic test_timer_edit();
        send_word(CMD_EDIT, any_key(), EDIT_TIMER);
        press(KEY_DOWN);
        press(KEY_UP);
        press(KEY_LEFT);
        press(KEY_UP);
        press(KEY_UP | KEY_RIGHT);
        press(KEY_CONFIRM);
    endtask

    // Clock edit: hour ones at 4, then hour tens to 2 clamps them to 3, and
    // with hour tens at 2 a further up on hour ones wraps past 3 to 0.
    task automatic test_clock_edit();
        send_word(CMD_EDIT, any_key(), EDIT_CLOCK);
        press(KEY_UP);
        press(KEY_RIGHT);
        repeat (4) press(KEY_UP);
        press(KEY_LEFT);
        press(KEY_UP);
        press(KEY_RIGHT);
        press(KEY_UP);
        press(KEY_CONFIRM);
    endtask

    // Outside the editor: up pauses and resumes, down is ignored and cancel
    // clears the timer into the expired state. Then an editor reopened on a
    // new target starts from a clean buffer and is cancelled.
    task automatic test_idle_keys();
        press(KEY_UP);
        press(KEY_UP);
        press(KEY_DOWN);
        press(KEY_CANCEL);
        send_word(CMD_EDIT, any_key(), EDIT_CLOCK);
        press(KEY_UP);
        send_word(CMD_EDIT, any_key(), EDIT_TIMER);
        press(KEY_CANCEL);
    endtask

    // Runs on the reset prescale value: 00:02 must step only on the
    // thousandth tick.
    task automatic test_default_prescaler();
        send_word(CMD_EDIT, any_key(), EDIT_TIMER);
        press(KEY_LEFT);
        press(KEY_UP);
        press(KEY_UP);
        press(KEY_CONFIRM);
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        tick_run(1001);
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // Prescale corner values: zero steps on every tick, the maximum does not
    // get there in the ticks it is given, ticks keep counting with the editor
    // open, and a limit dropped below the current count steps on the next tick.
    // The run ends past expiry, where further ticks are ignored.
    task automatic test_prescaler_edges();
        send_word(CMD_EDIT, any_key(), EDIT_TIMER);
        press(KEY_LEFT);
        repeat (3) press(KEY_UP);
        press(KEY_CONFIRM);
        write_prescale(16'd0);
        tick_run(2);
        write_prescale(16'hFFFF);
        tick_run(3);
        write_prescale(16'd10);
        send_word(CMD_EDIT, any_key(), EDIT_CLOCK);
        tick_run(4);
        press(KEY_CANCEL);
        write_prescale(16'd3);
        tick_run(6);
    endtask

    // The result side refuses words for a long stretch while words keep
    // coming back to back, so the block fills and drops s_ready.
    task automatic test_output_backpressure();
        wait_drained();
        tx_burst       = 1'b1;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (48) send_word(cmd_t'($urandom_range(0, 3)), any_key(), any_bit());
        tx_burst = 1'b0;
        wait_drained();
    endtask

    // A well-formed editor session with random content. Timer sessions often
    // move to the seconds digit first so that short countdowns come up.
    task automatic random_edit_session();
        logic tgt;
        int   n;
        int   r;
        tgt = any_bit();
        send_word(CMD_EDIT, any_key(), tgt);
        if (tgt == EDIT_TIMER && any_bit()) press(KEY_LEFT);
        n = $urandom_range(0, 12);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 40)      press(KEY_UP);
            else if (r < 55) press(KEY_DOWN);
            else if (r < 70) press(KEY_RIGHT);
            else if (r < 82) press(KEY_LEFT);
            else if (r < 90) send_word(CMD_TICK, any_key(), any_bit());
            else if (r < 96) press(any_key());
            else             send_word(CMD_UNUSED, any_key(), any_bit());
        end
        r = $urandom_range(0, 99);
        if (r < 65)      press(KEY_CONFIRM);
        else if (r < 85) press(KEY_CANCEL);
        else if (r < 92) send_word(CMD_EDIT, any_key(), any_bit());
    endtask

    task automatic run_random_words(input int count);
        int stop;
        int r;
        stop = words_sent + count;
        while (words_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                random_edit_session();
            end else if (r < 75) begin
                tick_run($urandom_range(1, 24));
            end else if (r < 88) begin
                case ($urandom_range(0, 2))
                    0:       press(KEY_UP);
                    1:       press(KEY_CANCEL);
                    default: press(any_key());
                endcase
            end else begin
                send_word(cmd_t'($urandom_range(0, 3)), any_key(), any_bit());
            end
        end
    endtask

    // Random phases, each under its own prescale value and pacing. Some
    // phases run without idle cycles on one or both sides.
    task automatic test_random_mix();
        logic [15:0] limits[8];
        int          p;
        limits = '{16'd1, 16'd2, 16'd0, 16'd3, 16'hFFFF, 16'd7, 16'd1, 16'd1};
        limits[7] = 16'($urandom_range(1, 16));
        for (p = 0; p < 8; p++) begin
            write_prescale(limits[p]);
            tx_burst = (p == 2) || (p == 5);
            rx_burst = (p == 2) || (p == 6);
            run_random_words(RANDOM_WORDS / 8);
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // Result side: after each taken word it draws a number of cycles to hold
    // m_ready low. A hold request from a test overrides the draw.
    initial begin : result_sink
        int stall;
        stall = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else if (m_valid && m_ready) begin
                stall = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
            end else if (stall > 0) begin
                stall--;
            end
            m_ready <= (stall == 0);
        end
    end

    // Every taken result word is compared with the oldest prediction.
    always @(posedge aclk) begin : check_results
        status_t want;
        logic    bad;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            results_seen++;
            if (status_q.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("%0t: result word %0d arrived with nothing predicted",
                             $realtime, results_seen);
                end
            end else begin
                want = status_q.pop_front();
                bad  = (m_edit_active     !== want.edit_active) ||
                       (m_edit_target_out !== want.edit_target) ||
                       (m_cursor_pos      !== want.cursor)      ||
                       (m_edit_value      !== want.edit_value)  ||
                       (m_timer_value     !== want.timer_value) ||
                       (m_clock_value     !== want.clock_value) ||
                       (m_is_running      !== want.running)     ||
                       (m_is_expired      !== want.expired)     ||
                       (m_committed       !== want.committed)   ||
                       (m_cancelled       !== want.cancelled);
                if (bad) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("%0t: result word %0d mismatch", $realtime, results_seen);
                        $display("  expected edit=%b tgt=%b cur=%0d buf=%h tmr=%h clk=%h",
                                 want.edit_active, want.edit_target, want.cursor,
                                 want.edit_value, want.timer_value, want.clock_value);
                        $display("           run=%b exp=%b com=%b can=%b",
                                 want.running, want.expired, want.committed,
                                 want.cancelled);
                        $display("  actual   edit=%b tgt=%b cur=%0d buf=%h tmr=%h clk=%h",
                                 m_edit_active, m_edit_target_out, m_cursor_pos,
                                 m_edit_value, m_timer_value, m_clock_value);
                        $display("           run=%b exp=%b com=%b can=%b",
                                 m_is_running, m_is_expired, m_committed, m_cancelled);
                    end
                end
            end
        end
    end

    // Main sequence. Reset is applied once, and the tests run in order. The
    // default prescale test must come before the first register write, since
    // it relies on the reset value.
    initial begin : run_regression
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_cmd       <= CMD_TICK;
        s_key       <= '0;
        s_target    <= 1'b0;
        tx_burst       = 1'b0;
        rx_burst       = 1'b0;
        rx_hold_cycles = 0;
        words_sent     = 0;
        results_seen   = 0;
        failures       = 0;
        commits        = 0;
        cancels        = 0;
        expiries       = 0;
        config_writes  = 0;
        clear_prediction();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_and_unused();
        test_timer_edit();
        test_clock_edit();
        test_idle_keys();
        test_default_prescaler();
        test_prescaler_edges();
        test_output_backpressure();
        test_random_mix();

        wait_drained();
        if (status_q.size() != 0) begin
            $display("%0d predicted result words never arrived", status_q.size());
            failures += status_q.size();
        end
        $display("Checked %0d result words for %0d input words over %0d prescale writes.",
                 results_seen, words_sent, config_writes);
        $display("Seen: %0d commits, %0d cancels, %0d countdown expiries.",
                 commits, cancels, expiries);
        if (failures == 0) begin
            $display("bcd_countdown_timer_with_digit_editor regression: pass");
        end else begin
            $display("bcd_countdown_timer_with_digit_editor regression: fail");
        end
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("bcd_countdown_timer_with_digit_editor regression: fail");
        $finish;
    end

endmodule
